// ===== rtl/sadf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the store address and data formatter.
// No dependencies.
package sadf_pkg;

    localparam int XLEN    = 64;
    localparam int IMM_W   = 16;
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        MODE_D,
        MODE_DS,
        MODE_X,
        MODE_XC
    } sadf_mode_t;

    typedef enum logic [1:0] {
        SIZE_B,
        SIZE_H,
        SIZE_W,
        SIZE_D
    } sadf_size_t;

    // one transaction as it sits between address generation and commit
    typedef struct packed {
        logic [XLEN-1:0] ea;
        logic [XLEN-1:0] data;
        logic [1:0]      size;
        logic            upd;
        logic            cond;
        logic            rvalid;
        logic [XLEN-1:0] raddr;
        logic            so;
    } sadf_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } sadf_qstat_t;

endpackage

// ===== rtl/store_address_and_data_formatter.sv =====
`timescale 1ns / 1ps
// Store address and data formatter, top level. Uses sadf_pkg, sadf_front,
// sadf_queue and sadf_back.
// Path: an accepted store is written into the queue, then loaded into the result
// register when popped. Throughput: one store per cycle while out_ready is high;
// the queue pushes and pops in the same cycle and the result register reloads as it
// drains. Reset (async) clears queue and out_valid.
module store_address_and_data_formatter
    import sadf_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic              update,
    input  logic              reversed,
    input  logic [1:0]        size,
    input  logic [4:0]        base_index,
    input  logic [XLEN-1:0]   base_value,
    input  logic [XLEN-1:0]   index_value,
    input  logic [IMM_W-1:0]  immediate,
    input  logic [XLEN-1:0]   source_value,
    input  logic              reserve_valid,
    input  logic [XLEN-1:0]   reserve_address,
    input  logic              summary_overflow,
    output logic              out_valid,
    input  logic              out_ready,
    output logic              write_enable,
    output logic [XLEN-1:0]   write_address,
    output logic [XLEN-1:0]   write_data,
    output logic [1:0]        write_size,
    output logic              base_update,
    output logic              cr0_write,
    output logic [3:0]        cr0_value,
    output logic              clear_reservation
);

    sadf_qstat_t qstat;
    sadf_item_t  push_item;
    sadf_item_t  head_item;
    logic        push;
    logic        pop;

    sadf_front u_front (
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .mode             (mode),
        .update           (update),
        .reversed         (reversed),
        .size             (size),
        .base_index       (base_index),
        .base_value       (base_value),
        .index_value      (index_value),
        .immediate        (immediate),
        .source_value     (source_value),
        .reserve_valid    (reserve_valid),
        .reserve_address  (reserve_address),
        .summary_overflow (summary_overflow),
        .qstat            (qstat),
        .push             (push),
        .push_item        (push_item)
    );

    sadf_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .pop       (pop),
        .head_item (head_item),
        .qstat     (qstat)
    );

    sadf_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .head_item         (head_item),
        .qstat             (qstat),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .write_enable      (write_enable),
        .write_address     (write_address),
        .write_data        (write_data),
        .write_size        (write_size),
        .base_update       (base_update),
        .cr0_write         (cr0_write),
        .cr0_value         (cr0_value),
        .clear_reservation (clear_reservation)
    );

endmodule

// ===== rtl/sadf_front.sv =====
`timescale 1ns / 1ps
// Front end: accepts store transactions, forms the effective address and
// the formatted store data. Depends on sadf_pkg.
module sadf_front
    import sadf_pkg::*;
(
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [1:0]        mode,
    input  logic              update,
    input  logic              reversed,
    input  logic [1:0]        size,
    input  logic [4:0]        base_index,
    input  logic [XLEN-1:0]   base_value,
    input  logic [XLEN-1:0]   index_value,
    input  logic [IMM_W-1:0]  immediate,
    input  logic [XLEN-1:0]   source_value,
    input  logic              reserve_valid,
    input  logic [XLEN-1:0]   reserve_address,
    input  logic              summary_overflow,
    input  sadf_qstat_t       qstat,
    output logic              push,
    output sadf_item_t        push_item
);

    logic [XLEN-1:0] offset;
    logic [XLEN-1:0] base;
    logic [XLEN-1:0] rev_all;
    logic [XLEN-1:0] plain;
    logic [XLEN-1:0] swapped;

    assign in_ready = !qstat.full;
    assign push     = in_valid && in_ready;

    always_comb
    begin
        unique case (sadf_mode_t'(mode))
            MODE_D:  offset = {{(XLEN-IMM_W){immediate[IMM_W-1]}}, immediate};
            MODE_DS: offset = {{(XLEN-IMM_W){immediate[IMM_W-1]}},
                               immediate[IMM_W-1:2], 2'b00};
            default: offset = index_value;
        endcase
    end

    assign base = (update || base_index != 5'd0) ? base_value : '0;

    always_comb
    begin
        for (int i = 0; i < 8; i++)
        begin
            rev_all[8*i +: 8] = source_value[8*(7-i) +: 8];
        end
    end

    always_comb
    begin
        unique case (sadf_size_t'(size))
            SIZE_B:
            begin
                plain   = {56'd0, source_value[7:0]};
                swapped = {56'd0, rev_all[63:56]};
            end
            SIZE_H:
            begin
                plain   = {48'd0, source_value[15:0]};
                swapped = {48'd0, rev_all[63:48]};
            end
            SIZE_W:
            begin
                plain   = {32'd0, source_value[31:0]};
                swapped = {32'd0, rev_all[63:32]};
            end
            SIZE_D:
            begin
                plain   = source_value;
                swapped = rev_all;
            end
        endcase
    end

    always_comb
    begin
        push_item.ea     = base + offset;
        push_item.data   = reversed ? swapped : plain;
        push_item.size   = size;
        push_item.upd    = update;
        push_item.cond   = (sadf_mode_t'(mode) == MODE_XC);
        push_item.rvalid = reserve_valid;
        push_item.raddr  = reserve_address;
        push_item.so     = summary_overflow;
    end

endmodule

// ===== rtl/sadf_queue.sv =====
`timescale 1ns / 1ps
// Short transaction queue between front and back end.
// Depends on sadf_pkg.
module sadf_queue
    import sadf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    input  sadf_item_t  push_item,
    input  logic        pop,
    output sadf_item_t  head_item,
    output sadf_qstat_t qstat
);

    sadf_item_t        mem [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign qstat.full  = (count_reg == QCNT_W'(QDEPTH));
    assign qstat.empty = (count_reg == '0);
    assign head_item   = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + QPTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// ===== rtl/sadf_back.sv =====
`timescale 1ns / 1ps
// Back end: reservation check for conditional stores and the result
// register. Depends on sadf_pkg.
module sadf_back
    import sadf_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  sadf_item_t      head_item,
    input  sadf_qstat_t     qstat,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            write_enable,
    output logic [XLEN-1:0] write_address,
    output logic [XLEN-1:0] write_data,
    output logic [1:0]      write_size,
    output logic            base_update,
    output logic            cr0_write,
    output logic [3:0]      cr0_value,
    output logic            clear_reservation
);

    logic            out_valid_reg, out_valid_next;
    logic            ok;
    logic            we_reg;
    logic [XLEN-1:0] addr_reg;
    logic [XLEN-1:0] data_reg;
    logic [1:0]      size_reg;
    logic            upd_reg;
    logic            crw_reg;
    logic [3:0]      cr0_reg;
    logic            clr_reg;

    assign pop = !qstat.empty && (!out_valid_reg || out_ready);
    assign ok  = !head_item.cond
                 || (head_item.rvalid && head_item.raddr == head_item.ea);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            we_reg   <= ok;
            addr_reg <= head_item.ea;
            data_reg <= ok ? head_item.data : '0;
            size_reg <= head_item.size;
            upd_reg  <= ok && head_item.upd;
            crw_reg  <= head_item.cond;
            cr0_reg  <= head_item.cond ? {2'b00, ok, head_item.so} : 4'd0;
            clr_reg  <= head_item.cond && ok;
        end
    end

    assign out_valid         = out_valid_reg;
    assign write_enable      = we_reg;
    assign write_address     = addr_reg;
    assign write_data        = data_reg;
    assign write_size        = size_reg;
    assign base_update       = upd_reg;
    assign cr0_write         = crw_reg;
    assign cr0_value         = cr0_reg;
    assign clear_reservation = clr_reg;

endmodule

// ===== rtl/sadf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the store formatter, bound to the top level.
// Depends on sadf_pkg and store_address_and_data_formatter.
module sadf_checker
    import sadf_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              in_valid,
    input logic              in_ready,
    input logic              out_valid,
    input logic              out_ready,
    input logic              write_enable,
    input logic [XLEN-1:0]   write_data,
    input logic              base_update,
    input logic              cr0_write,
    input logic [3:0]        cr0_value,
    input logic              clear_reservation
);

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_ready |=> in_valid)
        else $error("input transaction withdrawn while stalled");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_cond_outcome: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && cr0_write |->
            write_enable == cr0_value[1] && clear_reservation == cr0_value[1])
        else $error("conditional outcome disagrees with cr0");

    a_plain_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !cr0_write |->
            write_enable && cr0_value == 4'd0 && !clear_reservation)
        else $error("plain store reported as conditional");

    a_failed_store: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !write_enable |-> write_data == '0 && !base_update)
        else $error("failed store carries data or update");

endmodule

bind store_address_and_data_formatter sadf_checker u_sadf_checker (.*);

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// Testbench for store_address_and_data_formatter: random and directed stores,
// checked field by field against an in-bench predictor. Uses sadf_pkg.
module tb;
    import sadf_pkg::*;

    localparam int N_RANDOM   = 1200;
    localparam int IDLE_LIMIT = 1000;
    localparam int DRAIN_CYC  = 8;
    localparam int HOLD_CYC   = 60;
    localparam int HOLD_AT    = 300;

    typedef struct {
        sadf_mode_t      mode;
        logic            update;
        logic            reversed;
        sadf_size_t      size;
        logic [4:0]      base_index;
        logic [XLEN-1:0] base_value;
        logic [XLEN-1:0] index_value;
        logic [IMM_W-1:0] immediate;
        logic [XLEN-1:0] source_value;
        logic            reserve_valid;
        logic [XLEN-1:0] reserve_address;
        logic            summary_overflow;
    } store_req_t;

    typedef struct {
        logic            write_enable;
        logic [XLEN-1:0] write_address;
        logic [XLEN-1:0] write_data;
        logic [1:0]      write_size;
        logic            base_update;
        logic            cr0_write;
        logic [3:0]      cr0_value;
        logic            clear_reservation;
    } store_res_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic             in_valid = 1'b0;
    logic             in_ready;
    logic [1:0]       mode = '0;
    logic             update = 1'b0;
    logic             reversed = 1'b0;
    logic [1:0]       size = '0;
    logic [4:0]       base_index = '0;
    logic [XLEN-1:0]  base_value = '0;
    logic [XLEN-1:0]  index_value = '0;
    logic [IMM_W-1:0] immediate = '0;
    logic [XLEN-1:0]  source_value = '0;
    logic             reserve_valid = 1'b0;
    logic [XLEN-1:0]  reserve_address = '0;
    logic             summary_overflow = 1'b0;
    logic             out_valid;
    logic             out_ready = 1'b0;
    logic             write_enable;
    logic [XLEN-1:0]  write_address;
    logic [XLEN-1:0]  write_data;
    logic [1:0]       write_size;
    logic             base_update;
    logic             cr0_write;
    logic [3:0]       cr0_value;
    logic             clear_reservation;

    store_req_t store_queue[$];
    store_res_t pending_writes[$];
    store_req_t cur_store;
    int         total_stores = 0;
    int         stores_sent = 0;
    int         stores_loaded = 0;
    int         writes_seen = 0;
    int         mismatches = 0;
    int         send_gap = 0;
    int         recv_stall = 0;
    int         hold_left = 0;
    bit         hold_done = 1'b0;
    int         idle_cycles = 0;

    store_address_and_data_formatter u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .mode              (mode),
        .update            (update),
        .reversed          (reversed),
        .size              (size),
        .base_index        (base_index),
        .base_value        (base_value),
        .index_value       (index_value),
        .immediate         (immediate),
        .source_value      (source_value),
        .reserve_valid     (reserve_valid),
        .reserve_address   (reserve_address),
        .summary_overflow  (summary_overflow),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .write_enable      (write_enable),
        .write_address     (write_address),
        .write_data        (write_data),
        .write_size        (write_size),
        .base_update       (base_update),
        .cr0_write         (cr0_write),
        .cr0_value         (cr0_value),
        .clear_reservation (clear_reservation)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic store_res_t format_store(store_req_t r);
        store_res_t       o;
        logic [XLEN-1:0]  offs;
        logic [XLEN-1:0]  base;
        logic [XLEN-1:0]  ea;
        logic [XLEN-1:0]  data;
        logic [XLEN-1:0]  swapped;
        int               nbytes;
        logic             cond;
        logic             ok;
        case (r.mode)
            MODE_D:  offs = {{48{r.immediate[15]}}, r.immediate};
            MODE_DS: offs = {{48{r.immediate[15]}}, r.immediate[15:2], 2'b00};
            default: offs = r.index_value;
        endcase
        base = (r.update || r.base_index != 5'd0) ? r.base_value : '0;
        ea = base + offs;
        cond = (r.mode == MODE_XC);
        ok = !cond || (r.reserve_valid && r.reserve_address == ea);
        nbytes = 1 << r.size;
        if (nbytes == 8)
            data = r.source_value;
        else
            data = r.source_value & ((64'd1 << (8 * nbytes)) - 64'd1);
        if (r.reversed)
        begin
            swapped = '0;
            for (int i = 0; i < nbytes; i++)
                swapped = {swapped[55:0], data[8*i +: 8]};
            data = swapped;
        end
        o.write_enable      = ok;
        o.write_address     = ea;
        o.write_data        = ok ? data : '0;
        o.write_size        = r.size;
        o.base_update       = ok && r.update;
        o.cr0_write         = cond;
        o.cr0_value         = cond ? {2'b00, ok, r.summary_overflow} : 4'd0;
        o.clear_reservation = cond && ok;
        return o;
    endfunction

    function automatic logic [XLEN-1:0] rand64();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return 64'h8000_0000_0000_0000;
            3:       return 64'h7FFF_FFFF_FFFF_FFFF;
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic store_req_t mk_store(sadf_mode_t md, logic up, logic rv, sadf_size_t sz,
                                            logic [4:0] bi, logic [XLEN-1:0] bv,
                                            logic [XLEN-1:0] iv, logic [IMM_W-1:0] im,
                                            logic [XLEN-1:0] src, logic resv,
                                            logic [XLEN-1:0] ra, logic so);
        store_req_t r;
        r.mode = md;            r.update = up;          r.reversed = rv;
        r.size = sz;            r.base_index = bi;      r.base_value = bv;
        r.index_value = iv;     r.immediate = im;       r.source_value = src;
        r.reserve_valid = resv; r.reserve_address = ra; r.summary_overflow = so;
        return r;
    endfunction

    function automatic store_req_t match_reservation(store_req_t r);
        store_res_t p;
        p = format_store(r);
        r.reserve_address = p.write_address;
        return r;
    endfunction

    function automatic store_req_t random_store();
        store_req_t r;
        int         pick;
        r.mode = sadf_mode_t'($urandom_range(0, 3));
        if ($urandom_range(0, 2) == 0)
            r.mode = MODE_XC;
        r.update = 1'($urandom_range(0, 1));
        r.reversed = 1'($urandom_range(0, 1));
        r.size = sadf_size_t'($urandom_range(0, 3));
        r.base_index = ($urandom_range(0, 5) == 0) ? 5'd0 : 5'($urandom_range(0, 31));
        r.base_value = rand64();
        r.index_value = rand64();
        case ($urandom_range(0, 7))
            0:       r.immediate = 16'h8000;
            1:       r.immediate = 16'h7FFF;
            2:       r.immediate = 16'hFFFF;
            3:       r.immediate = 16'h0000;
            default: r.immediate = 16'($urandom);
        endcase
        r.source_value = rand64();
        r.reserve_valid = ($urandom_range(0, 4) != 0);
        r.reserve_address = rand64();
        r.summary_overflow = 1'($urandom_range(0, 1));
        pick = $urandom_range(0, 9);
        if (r.mode == MODE_XC && pick < 7)
            r = match_reservation(r);
        else if (r.mode == MODE_XC && pick == 7)
        begin
            r = match_reservation(r);
            r.reserve_address ^= 64'd1 << $urandom_range(0, 63);
        end
        return r;
    endfunction

    function automatic int draw_wait(int n);
        return ((n / 80) % 3 == 0) ? 0 : $urandom_range(0, 5);
    endfunction

    task automatic check_field(input string name, input logic [XLEN-1:0] want,
                               input logic [XLEN-1:0] got);
        if (want !== got)
        begin
            $error("%s: expected %h, got %h", name, want, got);
            mismatches++;
        end
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            send_gap = draw_wait(0);
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                pending_writes.push_back(format_store(cur_store));
                stores_sent++;
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    in_valid <= 1'b0;
                end
                else if (store_queue.size() > 0)
                begin
                    cur_store = store_queue.pop_front();
                    stores_loaded++;
                    send_gap = draw_wait(stores_loaded);
                    mode             <= cur_store.mode;
                    update           <= cur_store.update;
                    reversed         <= cur_store.reversed;
                    size             <= cur_store.size;
                    base_index       <= cur_store.base_index;
                    base_value       <= cur_store.base_value;
                    index_value      <= cur_store.index_value;
                    immediate        <= cur_store.immediate;
                    source_value     <= cur_store.source_value;
                    reserve_valid    <= cur_store.reserve_valid;
                    reserve_address  <= cur_store.reserve_address;
                    summary_overflow <= cur_store.summary_overflow;
                    in_valid         <= 1'b1;
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // monitor and checker
    always @(posedge clk or negedge rst_n)
    begin
        store_res_t want;
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            recv_stall = 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                writes_seen++;
                if (pending_writes.size() == 0)
                begin
                    $error("result transaction with no store outstanding");
                    mismatches++;
                end
                else
                begin
                    want = pending_writes.pop_front();
                    check_field("write_enable", 64'(want.write_enable), 64'(write_enable));
                    check_field("write_address", want.write_address, write_address);
                    check_field("write_data", want.write_data, write_data);
                    check_field("write_size", 64'(want.write_size), 64'(write_size));
                    check_field("base_update", 64'(want.base_update), 64'(base_update));
                    check_field("cr0_write", 64'(want.cr0_write), 64'(cr0_write));
                    check_field("cr0_value", 64'(want.cr0_value), 64'(cr0_value));
                    check_field("clear_reservation", 64'(want.clear_reservation),
                                64'(clear_reservation));
                end
                recv_stall = draw_wait(writes_seen + 40);
                if (writes_seen == HOLD_AT && !hold_done)
                begin
                    hold_done = 1'b1;
                    hold_left = HOLD_CYC;
                end
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else if (recv_stall > 0)
            begin
                recv_stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    initial
    begin
        store_req_t r;
        logic [XLEN-1:0] pat;
        pat = 64'h0123_4567_89AB_CDEF;
        // zero base, D offset extremes, DS low bits dropped
        store_queue.push_back(mk_store(MODE_D, 0, 0, SIZE_B, 5'd0, '1, '0, 16'h7FFF,
                                       '1, 0, '0, 0));
        store_queue.push_back(mk_store(MODE_D, 1, 1, SIZE_H, 5'd31, '1, '0, 16'h8000,
                                       pat, 1, '1, 1));
        store_queue.push_back(mk_store(MODE_DS, 0, 1, SIZE_W, 5'd7, 64'h1000, '0, 16'hFFFF,
                                       pat, 0, '0, 0));
        store_queue.push_back(mk_store(MODE_DS, 1, 0, SIZE_D, 5'd0, '0, '1, 16'h0003,
                                       '0, 1, '0, 1));
        // indexed wrap, update with base register zero
        store_queue.push_back(mk_store(MODE_X, 0, 1, SIZE_D, 5'd3, '1, 64'd1, 16'hFFFF,
                                       pat, 0, '0, 0));
        store_queue.push_back(mk_store(MODE_X, 1, 0, SIZE_W, 5'd0, 64'hDEAD_0000, 64'h10,
                                       16'h0, '1, 1, '1, 1));
        // conditional: success with update, no reservation, address mismatch, success with zero base
        r = mk_store(MODE_XC, 1, 0, SIZE_D, 5'd4, 64'h8000_0000_0000_0000, 64'h40, '0,
                     pat, 1, '0, 1);
        store_queue.push_back(match_reservation(r));
        r = mk_store(MODE_XC, 1, 1, SIZE_W, 5'd5, 64'h2000, 64'h8, '0, pat, 0, '0, 1);
        store_queue.push_back(match_reservation(r));
        r = match_reservation(mk_store(MODE_XC, 1, 0, SIZE_H, 5'd6, 64'h3000, 64'h4, '0,
                                       pat, 1, '0, 0));
        r.reserve_address ^= 64'h8;
        store_queue.push_back(r);
        r = mk_store(MODE_XC, 0, 1, SIZE_B, 5'd0, 64'h5, '1, '0, '1, 1, '0, 0);
        store_queue.push_back(match_reservation(r));
        // every size, both byte orders
        for (int s = 0; s < 4; s++)
            for (int rv = 0; rv < 2; rv++)
                store_queue.push_back(mk_store(MODE_X, rv[0], rv[0], sadf_size_t'(s), 5'd31,
                                               64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
                                               16'h5555, pat, 0, '0, 0));
        for (int i = 0; i < N_RANDOM; i++)
            store_queue.push_back(random_store());
        total_stores = store_queue.size();

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        while (stores_sent < total_stores || pending_writes.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYC) @(negedge clk);

        if (mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
